[rtl/core/gccm_pkg.sv]
// Package: shared constants and types for the grid component column-max block.
package gccm_pkg;
	localparam int unsigned GCCM_MAX_ROWS = 64;
	localparam int unsigned GCCM_MAX_COLS = 64;
	localparam int unsigned RESULT_W = 13;
	localparam int unsigned DIM_W = 7;

	localparam logic CFG_GRID_ROWS = 1'b0;
	localparam logic CFG_GRID_COLS = 1'b1;

	typedef enum logic [4:0] {
		ST_CLEAR,     // sweep label store to zero
		ST_LOAD,      // accept cells
		ST_SCAN,      // issue read of cell and label at scan_q
		ST_SCAN_W,    // check cell and label
		ST_POP,       // pop one cell off the walk stack
		ST_POP_W,     // stack read data valid
		ST_NB,        // issue read of neighbour d
		ST_NB_W,      // neighbour data valid
		ST_SIZE,      // write region size
		ST_COL_INIT,  // start a column
		ST_COL_RD,    // read label at (row, col)
		ST_COL_W,     // label valid, read seen and size
		ST_COL_CHK,   // accumulate
		ST_COL_END,   // update best
		ST_SEEN_CLR,  // clear seen flags for the column
		ST_OUT        // present result
	} gccm_state_t;
endpackage

[rtl/core/grid_component_column_max.sv]
// Top level: 4-connected region labelling with per-column region-size maximum.
//
// channel   | dir | payload
// s_axis    | in  | tdata[0] = cell_req
// m_axis    | out | tdata[12:0] = best_column_total
// cfg       | in  | cfg_index 0 grid_rows, 1 grid_cols; cfg_data[6:0]
//
// After reset a clearing pass sweeps the label store and the seen flags,
// with s_axis_tready low. Cells load one per cycle.
// After the last cell the sequencer labels regions, then scans each column and,
// after each, clears the seen flag of each distinct label it marked there, then
// the result waits on m_axis_tready and the label store is swept again. cfg_ready
// is low from the last cell until the result is taken. Every step goes through
// single-port memories, one access a cycle.
module grid_component_column_max
	import gccm_pkg::*;
#(
	parameter int unsigned MAX_ROWS = GCCM_MAX_ROWS,
	parameter int unsigned MAX_COLS = GCCM_MAX_COLS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [0] cell_req
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [12:0] best_column_total
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);
	localparam int unsigned CELLS = MAX_ROWS * MAX_COLS;
	localparam int unsigned LABELS = CELLS / 2 + 2;
	localparam int unsigned AW = $clog2(CELLS + 1);
	localparam int unsigned IW = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int unsigned LW = $clog2(LABELS);
	localparam int unsigned RW = $clog2(MAX_ROWS + 1);
	localparam int unsigned CW = $clog2(MAX_COLS + 1);
	localparam int unsigned SW = AW + 1;
	localparam int unsigned PW = RW + CW;

	gccm_state_t state_q, state_d;

	logic [DIM_W-1:0] rows_reg_q, cols_reg_q;
	logic [AW-1:0] loaded_q;
	logic [AW-1:0] scan_q;
	logic [AW-1:0] sp_q;
	logic [LW-1:0] next_label_q;
	logic [AW-1:0] count_q;
	logic [RW-1:0] cur_r_q, r_q;
	logic [CW-1:0] cur_c_q, c_q;
	logic [1:0] dir_q;
	logic [IW-1:0] nb_q;
	logic [RW-1:0] nb_r_q;
	logic [CW-1:0] nb_c_q;
	logic [SW-1:0] sum_q;
	logic [SW-1:0] best_q;
	logic [LW-1:0] lab_q;
	logic [RW-1:0] scan_r_q;
	logic [CW-1:0] scan_c_q;

	// clamped dimensions
	logic [RW-1:0] rows;
	logic [CW-1:0] cols;
	always_comb begin
		if (rows_reg_q == '0) rows = RW'(1);
		else if (32'(rows_reg_q) > MAX_ROWS) rows = RW'(MAX_ROWS);
		else rows = RW'(rows_reg_q);
		if (cols_reg_q == '0) cols = CW'(1);
		else if (32'(cols_reg_q) > MAX_COLS) cols = CW'(MAX_COLS);
		else cols = CW'(cols_reg_q);
	end
	logic [AW-1:0] total;
	assign total = AW'(rows) * AW'(cols);

	// memories
	logic cell_we, cell_wd, cell_rd;
	logic [IW-1:0] cell_a;
	logic lab_we;
	logic [IW-1:0] lab_a;
	logic [LW-1:0] lab_wd, lab_rd;
	logic stk_we;
	logic [IW-1:0] stk_a;
	logic [PW-1:0] stk_wd, stk_rd;  // {row, col}
	logic size_we;
	logic [LW-1:0] size_a;
	logic [AW-1:0] size_wd, size_rd;
	logic seen_we, seen_wd, seen_rd;
	logic [LW-1:0] seen_a;
	logic [AW-1:0] seen_q;  // number of labels marked in column, for clearing
	logic [IW-1:0] seen_list_a;

	gccm_ram #(.WIDTH(1), .DEPTH(CELLS)) u_cell (
		.clk, .we(cell_we), .addr(cell_a), .wdata(cell_wd), .rdata(cell_rd));
	gccm_ram #(.WIDTH(LW), .DEPTH(CELLS)) u_label (
		.clk, .we(lab_we), .addr(lab_a), .wdata(lab_wd), .rdata(lab_rd));
	gccm_ram #(.WIDTH(PW), .DEPTH(CELLS)) u_stack (
		.clk, .we(stk_we), .addr(stk_a), .wdata(stk_wd), .rdata(stk_rd));
	gccm_ram #(.WIDTH(AW), .DEPTH(LABELS)) u_size (
		.clk, .we(size_we), .addr(size_a), .wdata(size_wd), .rdata(size_rd));
	gccm_ram #(.WIDTH(1), .DEPTH(LABELS)) u_seen (
		.clk, .we(seen_we), .addr(seen_a), .wdata(seen_wd), .rdata(seen_rd));
	// list of labels marked in the current column, in its own RAM of CELLS entries
	logic [LW-1:0] list_rd;
	logic list_we;
	gccm_ram #(.WIDTH(LW), .DEPTH(CELLS)) u_list (
		.clk, .we(list_we), .addr(seen_list_a), .wdata(lab_q), .rdata(list_rd));

	// neighbour for dir_q of (cur_r_q, cur_c_q)
	logic nb_ok;
	logic [RW-1:0] nr;
	logic [CW-1:0] nc;
	always_comb begin
		nb_ok = 1'b0;
		nr = cur_r_q;
		nc = cur_c_q;
		case (dir_q)
			2'd0: begin
				nb_ok = cur_r_q != '0;
				nr = cur_r_q - RW'(1);
			end
			2'd1: begin
				nb_ok = (cur_r_q + RW'(1)) < rows;
				nr = cur_r_q + RW'(1);
			end
			2'd2: begin
				nb_ok = cur_c_q != '0;
				nc = cur_c_q - CW'(1);
			end
			default: begin
				nb_ok = (cur_c_q + CW'(1)) < cols;
				nc = cur_c_q + CW'(1);
			end
		endcase
	end
	logic [IW-1:0] nb_idx;
	assign nb_idx = IW'(nr) * IW'(cols) + IW'(nc);

	logic s_acc, m_acc, full_label, last_load;
	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign m_acc = m_axis_tvalid && m_axis_tready;
	assign full_label = 32'(next_label_q) >= LABELS;
	assign last_load = (loaded_q >= AW'(CELLS) ? loaded_q : loaded_q + AW'(1)) >= total;
	assign cfg_ready = (state_q == ST_LOAD) || (state_q == ST_CLEAR);
	assign s_axis_tready = state_q == ST_LOAD;
	assign m_axis_tvalid = state_q == ST_OUT;
	assign m_axis_tdata = {3'b000, best_q[RESULT_W-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_reg_q <= DIM_W'(64);
			cols_reg_q <= DIM_W'(64);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_GRID_ROWS: rows_reg_q <= cfg_data[DIM_W-1:0];
				CFG_GRID_COLS: cols_reg_q <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	// next state and memory controls
	always_comb begin
		state_d = state_q;
		cell_we = 1'b0; cell_wd = s_axis_tdata[0]; cell_a = loaded_q[IW-1:0];
		lab_we = 1'b0; lab_wd = '0; lab_a = scan_q[IW-1:0];
		stk_we = 1'b0; stk_wd = {nb_r_q, nb_c_q}; stk_a = sp_q[IW-1:0];
		size_we = 1'b0; size_wd = count_q; size_a = lab_q;
		seen_we = 1'b0; seen_wd = 1'b1; seen_a = lab_rd;
		list_we = 1'b0; seen_list_a = seen_q[IW-1:0];
		case (state_q)
			ST_CLEAR: begin
				lab_we = 1'b1;
				// sweep the seen flags alongside the labels
				seen_a = scan_q[LW-1:0];
				seen_wd = 1'b0;
				seen_we = scan_q < AW'(LABELS);
				if (scan_q == AW'(CELLS - 1)) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cell_we = s_acc && (loaded_q < AW'(CELLS));
				if (s_acc && last_load) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				cell_a = scan_q[IW-1:0];
				if (scan_q >= total) state_d = ST_COL_INIT;
				else state_d = ST_SCAN_W;
			end
			ST_SCAN_W: begin
				if (cell_rd && lab_rd == '0 && !full_label) begin
					lab_we = 1'b1;
					lab_wd = next_label_q;
					stk_we = 1'b1;
					stk_wd = {scan_r_q, scan_c_q};
					stk_a = '0;
					state_d = ST_POP;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_POP: begin
				stk_a = sp_q[IW-1:0] - IW'(1);
				if (sp_q == '0) state_d = ST_SIZE;
				else state_d = ST_POP_W;
			end
			ST_POP_W: state_d = ST_NB;
			ST_NB: begin
				cell_a = nb_idx;
				lab_a = nb_idx;
				if (nb_ok) state_d = ST_NB_W;
				else if (dir_q == 2'd3) state_d = ST_POP;
			end
			ST_NB_W: begin
				lab_a = nb_q;
				if (cell_rd && lab_rd == '0 && sp_q < AW'(CELLS)) begin
					lab_we = 1'b1;
					lab_wd = lab_q;
					stk_we = 1'b1;
				end
				state_d = (dir_q == 2'd3) ? ST_POP : ST_NB;
			end
			ST_SIZE: begin
				size_we = 1'b1;
				state_d = ST_SCAN;
			end
			ST_COL_INIT: begin
				if (c_q >= cols) state_d = ST_OUT;
				else state_d = ST_COL_RD;
			end
			ST_COL_RD: begin
				lab_a = IW'(r_q) * IW'(cols) + IW'(c_q);
				if (r_q >= rows) state_d = ST_COL_END;
				else state_d = ST_COL_W;
			end
			ST_COL_W: begin
				seen_a = lab_rd;
				size_a = lab_rd;
				state_d = ST_COL_CHK;
			end
			ST_COL_CHK: begin
				seen_a = lab_q;
				if (lab_q != '0 && !seen_rd) begin
					seen_we = 1'b1;
					list_we = 1'b1;
				end
				state_d = ST_COL_RD;
			end
			ST_COL_END: begin
				seen_list_a = seen_q[IW-1:0] - IW'(1);
				state_d = (seen_q == '0) ? ST_COL_INIT : ST_SEEN_CLR;
			end
			ST_SEEN_CLR: begin
				// list_rd holds entry seen_q-1; fetch the one below it
				seen_a = list_rd;
				seen_we = 1'b1;
				seen_wd = 1'b0;
				seen_list_a = seen_q[IW-1:0] - IW'(2);
				state_d = (seen_q == AW'(1)) ? ST_COL_INIT : ST_SEEN_CLR;
			end
			ST_OUT: begin
				lab_a = scan_q[IW-1:0];
				if (m_acc) state_d = ST_CLEAR;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
			scan_q <= '0;
			sp_q <= '0;
			next_label_q <= LW'(1);
			count_q <= '0;
			dir_q <= '0;
			sum_q <= '0;
			best_q <= '0;
			r_q <= '0;
			c_q <= '0;
			seen_q <= '0;
			cur_r_q <= '0;
			cur_c_q <= '0;
			nb_q <= '0;
			nb_r_q <= '0;
			nb_c_q <= '0;
			lab_q <= '0;
			scan_r_q <= '0;
			scan_c_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: scan_q <= (scan_q == AW'(CELLS - 1)) ? '0 : scan_q + AW'(1);
				ST_LOAD: begin
					if (s_acc && loaded_q < AW'(CELLS)) loaded_q <= loaded_q + AW'(1);
					if (s_acc && last_load) begin
						scan_q <= '0;
						scan_r_q <= '0;
						scan_c_q <= '0;
					end
				end
				ST_SCAN_W: begin
					if (cell_rd && lab_rd == '0 && !full_label) begin
						lab_q <= next_label_q;
						next_label_q <= next_label_q + LW'(1);
						sp_q <= AW'(1);
						count_q <= '0;
					end
					scan_q <= scan_q + AW'(1);
					cur_r_q <= scan_r_q;
					cur_c_q <= scan_c_q;
					if (scan_c_q + CW'(1) >= cols) begin
						scan_c_q <= '0;
						scan_r_q <= scan_r_q + RW'(1);
					end else begin
						scan_c_q <= scan_c_q + CW'(1);
					end
				end
				ST_POP: if (sp_q != '0) sp_q <= sp_q - AW'(1);
				ST_POP_W: begin
					cur_r_q <= stk_rd[PW-1:CW];
					cur_c_q <= stk_rd[CW-1:0];
					count_q <= count_q + AW'(1);
					dir_q <= '0;
				end
				ST_NB: begin
					nb_q <= nb_idx;
					nb_r_q <= nr;
					nb_c_q <= nc;
					if (!nb_ok) dir_q <= dir_q + 2'd1;
				end
				ST_NB_W: begin
					if (cell_rd && lab_rd == '0 && sp_q < AW'(CELLS)) sp_q <= sp_q + AW'(1);
					dir_q <= dir_q + 2'd1;
				end
				ST_COL_INIT: begin
					r_q <= '0;
					sum_q <= '0;
				end
				ST_COL_W: lab_q <= lab_rd;
				ST_COL_CHK: begin
					if (lab_q != '0 && !seen_rd) begin
						sum_q <= sum_q + SW'(size_rd);
						seen_q <= seen_q + AW'(1);
					end
					r_q <= r_q + RW'(1);
				end
				ST_COL_END: begin
					if (sum_q > best_q) best_q <= sum_q;
					c_q <= c_q + CW'(1);
				end
				ST_SEEN_CLR: seen_q <= seen_q - AW'(1);
				ST_OUT: begin
					if (m_acc) begin
						loaded_q <= '0;
						scan_q <= '0;
						next_label_q <= LW'(1);
						best_q <= '0;
						c_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

[rtl/core/gccm_ram.sv]
// Generic single-port RAM with registered read.
module gccm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

[tb/tb_grid_component_column_max.sv]
// Testbench for grid_component_column_max: streams grids, predicts the best column total.
`timescale 1ns / 100ps

module tb_grid_component_column_max;
	import gccm_pkg::*;

	localparam int unsigned CELLS_MAX = GCCM_MAX_ROWS * GCCM_MAX_COLS;
	localparam int unsigned LABELS_MAX = CELLS_MAX / 2 + 2;
	localparam int unsigned SWEEP_WAIT = CELLS_MAX + 200;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [7:0]  cfg_data;

	// predictor copy of the block
	logic [DIM_W-1:0] rows_reg;
	logic [DIM_W-1:0] cols_reg;
	bit               grid_bits [CELLS_MAX];
	int unsigned      loaded_count;

	logic [RESULT_W-1:0] expected_totals [$];
	int unsigned fail_count;
	int unsigned result_count;
	int unsigned items_sent;
	int unsigned grids_done;
	bit          quiet;
	int unsigned stall_left;

	grid_component_column_max DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // [0] cell_req
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // [12:0] best_column_total
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("Some tests failed");
		$finish;
	end

	function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	// label 4-connected regions, then take the best sum of distinct sizes per column
	function automatic logic [RESULT_W-1:0] best_column_total(int unsigned rows,
			int unsigned cols);
		int unsigned lab [CELLS_MAX];
		int unsigned sz [LABELS_MAX];
		bit          seen [LABELS_MAX];
		int unsigned walk [$];
		int          dr [4];
		int          dc [4];
		int unsigned next_lab, cur, cnt, best, sum, l, n;
		int          r, k, nr, nk;
		dr = '{-1, 1, 0, 0};
		dc = '{0, 0, -1, 1};
		next_lab = 1;
		best = 0;
		for (int unsigned i = 0; i < rows * cols; i++) begin
			if (grid_bits[i] && lab[i] == 0 && next_lab < LABELS_MAX) begin
				l = next_lab++;
				lab[i] = l;
				walk.push_back(i);
				cnt = 0;
				while (walk.size() > 0) begin
					cur = walk.pop_back();
					r = cur / cols;
					k = cur % cols;
					cnt++;
					for (int d = 0; d < 4; d++) begin
						nr = r + dr[d];
						nk = k + dc[d];
						if (nr < 0 || nr >= int'(rows) || nk < 0 || nk >= int'(cols))
							continue;
						n = nr * cols + nk;
						if (!grid_bits[n] || lab[n] != 0) continue;
						lab[n] = l;
						walk.push_back(n);
					end
				end
				sz[l] = cnt;
			end
		end
		for (int unsigned j = 0; j < cols; j++) begin
			sum = 0;
			foreach (seen[s]) seen[s] = 1'b0;
			for (int unsigned i = 0; i < rows; i++) begin
				l = lab[i * cols + j];
				if (l != 0 && !seen[l]) begin
					seen[l] = 1'b1;
					sum += sz[l];
				end
			end
			if (sum > best) best = sum;
		end
		return best[RESULT_W-1:0];
	endfunction

	task automatic predict_item(bit b);
		int unsigned rows, cols;
		rows = clamp_dim(rows_reg, GCCM_MAX_ROWS);
		cols = clamp_dim(cols_reg, GCCM_MAX_COLS);
		if (loaded_count < CELLS_MAX) begin
			grid_bits[loaded_count] = b;
			loaded_count++;
		end
		if (loaded_count >= rows * cols) begin
			expected_totals.push_back(best_column_total(rows, cols));
			loaded_count = 0;
			grids_done++;
		end
	endtask

	// send one item; upper data bits carry noise that the block must ignore
	task automatic send_item(bit b);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'($urandom), b};
		do @(posedge clk); while (!s_axis_tready);
		predict_item(b);
		items_sent++;
	endtask

	// hold the sender until every result is in and the label sweep is over
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_totals.size() > 0) @(posedge clk);
		repeat (SWEEP_WAIT) @(posedge clk);
	endtask

	task automatic write_dims(logic [7:0] rows_raw, logic [7:0] cols_raw);
		s_axis_tvalid <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= CFG_GRID_ROWS;
		cfg_data  <= rows_raw;
		do @(posedge clk); while (!cfg_ready);
		rows_reg = rows_raw[DIM_W-1:0];
		cfg_index <= CFG_GRID_COLS;
		cfg_data  <= cols_raw;
		do @(posedge clk); while (!cfg_ready);
		cols_reg = cols_raw[DIM_W-1:0];
		cfg_valid <= 1'b0;
	endtask

	task automatic send_grid(int unsigned n, int unsigned density);
		for (int unsigned i = 0; i < n; i++)
			send_item($urandom_range(0, 99) < density);
	endtask

	// every cell set: one region covering the whole grid
	task automatic test_full_grid();
		write_dims(8'd12, 8'd12);
		send_grid(144, 100);
		drain();
	endtask

	task automatic test_small_extremes();
		write_dims(8'd1, 8'd1);
		send_item(1'b0);
		send_item(1'b1);
		drain();
		// two regions sharing columns, one region spanning two columns
		write_dims(8'd3, 8'd3);
		send_item(1'b1); send_item(1'b0); send_item(1'b1);
		send_item(1'b1); send_item(1'b0); send_item(1'b0);
		send_item(1'b0); send_item(1'b1); send_item(1'b1);
		drain();
	endtask

	// shrink the grid after more cells than the new size have arrived
	task automatic test_resize_mid_grid();
		write_dims(8'd8, 8'd8);
		send_grid(10, 60);
		write_dims(8'd2, 8'd4);
		send_item(1'b1);
		drain();
	endtask

	// out-of-range dimensions read as the nearest legal size; bit 7 dropped
	task automatic test_dim_clamp();
		write_dims(8'd0, 8'd127);
		send_grid(GCCM_MAX_COLS, 50);
		drain();
		write_dims(8'h82, 8'h83);
		send_grid(6, 70);
		drain();
	endtask

	task automatic test_random_grids();
		int unsigned start, rows, cols;
		logic [7:0] r_raw, c_raw;
		start = items_sent;
		while (items_sent - start < 380) begin
			if (items_sent - start > 300) quiet = 1'b1;
			rows = $urandom_range(1, 8);
			cols = $urandom_range(1, 8);
			if ($urandom_range(0, 7) == 0) rows = $urandom_range(9, 20);
			r_raw = 8'(rows);
			c_raw = 8'(cols);
			if ($urandom_range(0, 7) == 0) r_raw[7] = 1'b1;
			if ($urandom_range(0, 7) == 0) c_raw[7] = 1'b1;
			write_dims(r_raw, c_raw);
			send_grid(rows * cols, $urandom_range(0, 100));
			drain();
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n || quiet) begin
			m_axis_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 9);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			result_count++;
			if (expected_totals.size() == 0) begin
				$error("best_column_total: none expected, actual %0d", m_axis_tdata[12:0]);
				fail_count++;
			end else if (m_axis_tdata[12:0] !== expected_totals[0]) begin
				$error("best_column_total: expected %0d, actual %0d",
					expected_totals[0], m_axis_tdata[12:0]);
				fail_count++;
				void'(expected_totals.pop_front());
			end else begin
				void'(expected_totals.pop_front());
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b1;
		cfg_valid     = 1'b0;
		cfg_index     = CFG_GRID_ROWS;
		cfg_data      = '0;
		rows_reg      = 7'd64;
		cols_reg      = 7'd64;
		loaded_count  = 0;
		fail_count    = 0;
		result_count  = 0;
		items_sent    = 0;
		grids_done    = 0;
		quiet         = 1'b0;
		stall_left    = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_full_grid();
		test_small_extremes();
		test_resize_mid_grid();
		test_dim_clamp();
		test_random_grids();

		drain();
		repeat (50) @(posedge clk);
		if (expected_totals.size() != 0) begin
			$error("best_column_total: %0d results never arrived", expected_totals.size());
			fail_count++;
		end
		$display("Covered %0d grids from %0d cells, %0d column totals checked.",
			grids_done, items_sent, result_count);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

[filelist.f]
rtl/core/gccm_pkg.sv
rtl/core/gccm_ram.sv
rtl/core/grid_component_column_max.sv
tb/tb_grid_component_column_max.sv
